FILE: sv/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg: shared definitions for the daily schedule intensity block
// Field widths, time constants, slot register layout and reset values, and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dsi_pkg;

  localparam int SlotCount = 8;   // slots scanned, 2..8
  localparam int RegCount  = 8;   // slot registers present
  localparam int RegIdxW   = 3;
  localparam int CfgIdxW   = 4;
  localparam int CfgW      = 31;

  localparam int TimeW    = 27;
  localparam int SgnW     = TimeW + 2;
  localparam int MinW     = 11;
  localparam int ModeW    = 2;
  localparam int LevelW   = 7;
  localparam int IntW     = 15;
  localparam int SlotOutW = 4;

  localparam int FracBits = 8;
  localparam int QuotW    = IntW;
  localparam int DurW     = TimeW;
  localparam int NumW     = DurW + LevelW;
  localparam int RemW     = DurW + 1;
  localparam int DivCntW  = $clog2(QuotW);

  localparam int MsPerMin = 60 * 1000;
  localparam int MsPerDay = 24 * 3600 * 1000;
  localparam int FullQ8   = 25600;

  // slot register layout
  localparam int StartLsb = 0;
  localparam int EndLsb   = 11;
  localparam int ModeLsb  = 22;
  localparam int LevelLsb = 24;

  localparam logic [ModeW-1:0] ModeFixed = 2'd2;

  localparam logic [CfgW-1:0] SlotReset [RegCount] = '{
    31'd1686847488, 31'd1678705000, 31'd1688322528, 31'd1684374584,
    31'd11338928,   31'd8388608,    31'd8388608,    31'd8388608
  };

  typedef struct packed {
    logic               start;
    logic               rd;
    logic               test;
    logic               clamp;
    logic               mul1;
    logic               mul2;
    logic               div;
    logic               emit;
    logic [RegIdxW-1:0] idx;
  } dsi_cmd_t;

  typedef struct packed {
    logic hit;
    logic fixed;
    logic out_blocked;
  } dsi_sts_t;

endpackage

FILE: sv/dsi_ctrl.sv
// ----------------------------------------------------------------------------
// dsi_ctrl: sequencer for the schedule lookup
// Walks the slot scan (read, test per slot), the range clamp, the two multiply
// steps and bit-serial divide for a ramp slot, and the result transfer.
// ----------------------------------------------------------------------------
module dsi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dsi_pkg::dsi_sts_t  sts_i,
  output dsi_pkg::dsi_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_CLAMP,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                            state_q;
  logic [dsi_pkg::RegIdxW-1:0]       idx_q;
  logic [dsi_pkg::DivCntW-1:0]       cnt_q;

  assign in_stall_o = (state_q != ST_IDLE);

  assign cmd_o.start = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.rd    = (state_q == ST_READ);
  assign cmd_o.test  = (state_q == ST_TEST);
  assign cmd_o.clamp = (state_q == ST_CLAMP);
  assign cmd_o.mul1  = (state_q == ST_MUL1);
  assign cmd_o.mul2  = (state_q == ST_MUL2);
  assign cmd_o.div   = (state_q == ST_DIV);
  assign cmd_o.emit  = (state_q == ST_EMIT);
  assign cmd_o.idx   = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
            idx_q   <= '0;
          end
        end
        ST_READ: begin
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          // scan every slot so the wrap-around predecessor is known
          if (idx_q == dsi_pkg::RegIdxW'(dsi_pkg::SlotCount - 1)) begin
            state_q <= ST_CLAMP;
          end else begin
            idx_q   <= idx_q + dsi_pkg::RegIdxW'(1);
            state_q <= ST_READ;
          end
        end
        ST_CLAMP: begin
          if (sts_i.hit && !sts_i.fixed) begin
            state_q <= ST_MUL1;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_MUL1: begin
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          if (cnt_q == dsi_pkg::DivCntW'(dsi_pkg::QuotW - 1)) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q + dsi_pkg::DivCntW'(1);
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!sts_i.out_blocked) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

FILE: sv/dsi_dpath.sv
// ----------------------------------------------------------------------------
// dsi_dpath: datapath for the schedule lookup
// Slot registers, window test, elapsed/duration clamp, interpolation
// products, restoring divider and the output register.
// ----------------------------------------------------------------------------
module dsi_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dsi_pkg::dsi_cmd_t               cmd_i,
  output dsi_pkg::dsi_sts_t               sts_o,
  input  logic [dsi_pkg::TimeW-1:0]       time_of_day_ms_i,
  input  logic                            cfg_valid_i,
  input  logic [dsi_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dsi_pkg::CfgW-1:0]        cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dsi_pkg::IntW-1:0]        intensity_q8_o,
  output logic [dsi_pkg::SlotOutW-1:0]    active_slot_o
);

  localparam int IntPart = dsi_pkg::QuotW - dsi_pkg::FracBits;

  // slot registers
  logic [dsi_pkg::CfgW-1:0] slot_q [dsi_pkg::RegCount];
  logic                     cfg_we;

  assign cfg_we = cfg_valid_i &&
                  (cfg_index_i < dsi_pkg::CfgIdxW'(dsi_pkg::RegCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dsi_pkg::RegCount; i++) begin
        slot_q[i] <= dsi_pkg::SlotReset[i];
      end
    end else if (cfg_we) begin
      slot_q[cfg_index_i[dsi_pkg::RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  // slot read and field decode
  logic [dsi_pkg::CfgW-1:0]   rd_word;
  logic [dsi_pkg::MinW-1:0]   rd_start;
  logic [dsi_pkg::MinW-1:0]   rd_end;

  assign rd_word  = slot_q[cmd_i.idx];
  assign rd_start = rd_word[dsi_pkg::StartLsb +: dsi_pkg::MinW];
  assign rd_end   = rd_word[dsi_pkg::EndLsb +: dsi_pkg::MinW];

  logic [dsi_pkg::TimeW-1:0]  t_q;
  logic [dsi_pkg::TimeW-1:0]  s_q, e_q;
  logic                       en_q;
  logic [dsi_pkg::LevelW-1:0] lvl_q;
  logic [dsi_pkg::ModeW-1:0]  mode_q;

  // window test
  logic signed [dsi_pkg::SgnW-1:0] t_s, s_s, e_s, day_s;
  logic signed [dsi_pkg::SgnW-1:0] el_now, dur_now;
  logic                            hit_now;

  assign t_s   = signed'({2'b00, t_q});
  assign s_s   = signed'({2'b00, s_q});
  assign e_s   = signed'({2'b00, e_q});
  assign day_s = signed'(dsi_pkg::SgnW'(dsi_pkg::MsPerDay));

  always_comb begin
    if (e_q > s_q) begin
      hit_now = en_q && (t_q >= s_q) && (t_q < e_q);
      dur_now = e_s - s_s;
    end else if (e_q < s_q) begin
      hit_now = en_q && ((t_q >= s_q) || (t_q < e_q));
      dur_now = day_s - s_s + e_s;
    end else begin
      hit_now = 1'b0;
      dur_now = e_s - s_s;
    end
    el_now = (t_q >= s_q) ? (t_s - s_s) : (t_s + day_s - s_s);
  end

  // scan results
  logic                            hit_q;
  logic [dsi_pkg::RegIdxW-1:0]     hit_idx_q;
  logic [dsi_pkg::LevelW-1:0]      hit_lvl_q;
  logic                            hit_fixed_q;
  logic signed [dsi_pkg::SgnW-1:0] el_raw_q, dur_raw_q;
  logic                            prev_valid_q;
  logic [dsi_pkg::LevelW-1:0]      prev_lvl_q;
  logic                            last_en_valid_q;
  logic [dsi_pkg::LevelW-1:0]      last_en_lvl_q;
  logic [dsi_pkg::RegIdxW-1:0]     last_en_idx_q;

  // clamp, products, divider
  logic [dsi_pkg::DurW-1:0]   dur_q, el_q, dur_d, el_d;
  logic [dsi_pkg::LevelW-1:0] startv_q, startv_d;
  logic [dsi_pkg::NumW-1:0]   p1_q, num;
  logic [dsi_pkg::RemW-1:0]   rem_q, trial, dur_ext;
  logic [dsi_pkg::QuotW-1:0]  dq_q;
  logic                       ge;

  always_comb begin
    if (dur_raw_q <= 0) begin
      dur_d = dsi_pkg::DurW'(1);
      el_d  = '0;
    end else begin
      dur_d = dur_raw_q[dsi_pkg::DurW-1:0];
      if (el_raw_q < 0) begin
        el_d = '0;
      end else if (el_raw_q > dur_raw_q) begin
        el_d = dur_raw_q[dsi_pkg::DurW-1:0];
      end else begin
        el_d = el_raw_q[dsi_pkg::DurW-1:0];
      end
    end
    // predecessor: last enabled slot before the hit, else the highest one after
    if (prev_valid_q) begin
      startv_d = prev_lvl_q;
    end else if (last_en_valid_q && (last_en_idx_q != hit_idx_q)) begin
      startv_d = last_en_lvl_q;
    end else begin
      startv_d = '0;
    end
  end

  assign num     = p1_q + dsi_pkg::NumW'(hit_lvl_q) * dsi_pkg::NumW'(el_q);
  assign dur_ext = {1'b0, dur_q};
  assign trial   = {rem_q[dsi_pkg::RemW-2:0], dq_q[dsi_pkg::QuotW-1]};
  assign ge      = (trial >= dur_ext);

  // result select
  logic                          blocked, load;
  logic [dsi_pkg::IntW-1:0]      res_val, res_clamped, last_q;
  logic                          out_valid_q;
  logic [dsi_pkg::IntW-1:0]      out_int_q;
  logic [dsi_pkg::SlotOutW-1:0]  out_slot_q;

  assign blocked = out_valid_q && out_stall_i;
  assign load    = cmd_i.emit && !blocked;

  always_comb begin
    res_val     = hit_fixed_q ? {hit_lvl_q, dsi_pkg::FracBits'(0)} : dq_q;
    res_clamped = (res_val > dsi_pkg::IntW'(dsi_pkg::FullQ8)) ?
                  dsi_pkg::IntW'(dsi_pkg::FullQ8) : res_val;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q           <= 1'b0;
      last_en_valid_q <= 1'b0;
      out_valid_q     <= 1'b0;
      last_q          <= '0;
    end else begin
      if (cmd_i.start) begin
        hit_q           <= 1'b0;
        last_en_valid_q <= 1'b0;
      end else if (cmd_i.test && en_q) begin
        last_en_valid_q <= 1'b1;
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
        if (hit_q) begin
          last_q <= res_clamped;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q <= time_of_day_ms_i;
    end
    if (cmd_i.rd) begin
      s_q    <= dsi_pkg::TimeW'(rd_start * dsi_pkg::MsPerMin);
      e_q    <= dsi_pkg::TimeW'(rd_end * dsi_pkg::MsPerMin);
      en_q   <= (rd_start != '0) || (rd_end != '0);
      lvl_q  <= rd_word[dsi_pkg::LevelLsb +: dsi_pkg::LevelW];
      mode_q <= rd_word[dsi_pkg::ModeLsb +: dsi_pkg::ModeW];
    end
    if (cmd_i.test && en_q) begin
      // first hit only: capture window and the predecessor seen so far
      if (hit_now && !hit_q) begin
        hit_idx_q    <= cmd_i.idx;
        hit_lvl_q    <= lvl_q;
        hit_fixed_q  <= (mode_q == dsi_pkg::ModeFixed);
        el_raw_q     <= el_now;
        dur_raw_q    <= dur_now;
        prev_valid_q <= last_en_valid_q;
        prev_lvl_q   <= last_en_lvl_q;
      end
      last_en_lvl_q <= lvl_q;
      last_en_idx_q <= cmd_i.idx;
    end
    if (cmd_i.clamp) begin
      dur_q    <= dur_d;
      el_q     <= el_d;
      startv_q <= startv_d;
    end
    if (cmd_i.mul1) begin
      p1_q <= dsi_pkg::NumW'(startv_q) * dsi_pkg::NumW'(dur_q - el_q);
    end
    if (cmd_i.mul2) begin
      // numerator is num * 256; quotient fits QuotW bits
      rem_q <= dsi_pkg::RemW'(num >> IntPart);
      dq_q  <= {num[IntPart-1:0], dsi_pkg::FracBits'(0)};
    end
    if (cmd_i.div) begin
      rem_q <= ge ? (trial - dur_ext) : trial;
      dq_q  <= {dq_q[dsi_pkg::QuotW-2:0], ge};
    end
    if (load) begin
      out_int_q  <= hit_q ? res_clamped : last_q;
      out_slot_q <= hit_q ? ({1'b0, hit_idx_q} + dsi_pkg::SlotOutW'(1)) : '0;
    end
  end

  assign sts_o.hit         = hit_q;
  assign sts_o.fixed       = hit_fixed_q;
  assign sts_o.out_blocked = blocked;

  assign out_valid_o    = out_valid_q;
  assign intensity_q8_o = out_int_q;
  assign active_slot_o  = out_slot_q;

endmodule

FILE: sv/daily_schedule_intensity_core.sv
// Sequence: input transfer, slot scan (a read and a test per slot), range clamp,
//   the multiply steps and divide for an interpolating slot, then the result.
// Input: a new time is taken only after the result of the last one has been
//   loaded into the output register; the divider yields one bit per cycle.
// Reset: slot registers take their default schedule, last intensity clears to 0,
//   no result is pending.
// ----------------------------------------------------------------------------
// daily_schedule_intensity_core: scheduled intensity from time of day
// Scans eight schedule slots for the window that holds the given time and
// returns a fixed or linearly interpolated intensity, percent in Q8.
// ----------------------------------------------------------------------------
module daily_schedule_intensity_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dsi_pkg::TimeW-1:0]       time_of_day_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dsi_pkg::IntW-1:0]        intensity_q8_o,
  output logic [dsi_pkg::SlotOutW-1:0]    active_slot_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dsi_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dsi_pkg::CfgW-1:0]        cfg_data_i
);

  dsi_pkg::dsi_cmd_t cmd;
  dsi_pkg::dsi_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsi_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .time_of_day_ms_i (time_of_day_ms_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .intensity_q8_o   (intensity_q8_o),
    .active_slot_o    (active_slot_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_slot_o <= dsi_pkg::SlotOutW'(dsi_pkg::SlotCount)))
    else $error("active slot beyond scanned slots");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (intensity_q8_o <= dsi_pkg::IntW'(dsi_pkg::FullQ8)))
    else $error("intensity above full scale");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared one cycle after a transfer");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: daily schedule intensity core
// Drives times of day against a range of slot schedules, predicts each
// intensity and slot number in step with the block and checks every result
// in order, with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QuietLimit  = 3000;  // cycles with no transfer on any channel
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 120;
  localparam int PhaseCount  = 14;

  localparam logic [dsi_pkg::ModeW-1:0] ModeRamp    = 2'd0;
  localparam logic [dsi_pkg::ModeW-1:0] ModeRampAlt = 2'd1;
  localparam logic [dsi_pkg::ModeW-1:0] ModeRampOdd = 2'd3;

  typedef struct packed {
    logic [dsi_pkg::IntW-1:0]     q8;
    logic [dsi_pkg::SlotOutW-1:0] slot;
  } level_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [dsi_pkg::TimeW-1:0]    time_of_day_ms_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [dsi_pkg::IntW-1:0]     intensity_q8_o;
  logic [dsi_pkg::SlotOutW-1:0] active_slot_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [dsi_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [dsi_pkg::CfgW-1:0]     cfg_data_i;

  // predictor state: slot registers as written, last intensity
  logic [dsi_pkg::CfgW-1:0] sched [dsi_pkg::RegCount];
  logic [dsi_pkg::IntW-1:0] last_q8;
  logic [dsi_pkg::CfgW-1:0] plan [dsi_pkg::RegCount];
  level_t                   due_levels [$];

  int errors       = 0;
  int quiet_cycles = 0;
  int hold_len     = 0;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;

  daily_schedule_intensity_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .time_of_day_ms_i (time_of_day_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .intensity_q8_o   (intensity_q8_o),
    .active_slot_o    (active_slot_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit slot_on(input logic [dsi_pkg::CfgW-1:0] w);
    return (w[dsi_pkg::StartLsb +: dsi_pkg::MinW] != '0) ||
           (w[dsi_pkg::EndLsb +: dsi_pkg::MinW] != '0);
  endfunction

  function automatic logic [dsi_pkg::CfgW-1:0] pack_slot(
    input int                        first_min,
    input int                        last_min,
    input logic [dsi_pkg::ModeW-1:0] mode,
    input int                        level
  );
    logic [dsi_pkg::CfgW-1:0] w;
    w = '0;
    w[dsi_pkg::StartLsb +: dsi_pkg::MinW]   = dsi_pkg::MinW'(first_min);
    w[dsi_pkg::EndLsb +: dsi_pkg::MinW]     = dsi_pkg::MinW'(last_min);
    w[dsi_pkg::ModeLsb +: dsi_pkg::ModeW]   = mode;
    w[dsi_pkg::LevelLsb +: dsi_pkg::LevelW] = dsi_pkg::LevelW'(level);
    return w;
  endfunction

  // First enabled slot whose window holds t; fixed level or linear ramp from
  // the previous enabled slot's level.
  function automatic level_t predict_level(input logic [dsi_pkg::TimeW-1:0] t);
    level_t                   res;
    longint                   tm, s, e, el, dur, from_lv, to_lv, num, q;
    int                       hit, p, i;
    logic [dsi_pkg::CfgW-1:0] w;
    tm  = longint'(t);
    hit = -1;
    el  = 0;
    dur = 1;
    for (i = 0; i < dsi_pkg::SlotCount; i++) begin
      w = sched[i];
      if (hit < 0 && slot_on(w)) begin
        s = longint'(w[dsi_pkg::StartLsb +: dsi_pkg::MinW]) * dsi_pkg::MsPerMin;
        e = longint'(w[dsi_pkg::EndLsb +: dsi_pkg::MinW]) * dsi_pkg::MsPerMin;
        if (e > s && tm >= s && tm < e) begin
          hit = i;
          el  = tm - s;
          dur = e - s;
        end else if (e < s && (tm >= s || tm < e)) begin
          hit = i;
          dur = dsi_pkg::MsPerDay - s + e;
          if (tm >= s) el = tm - s;
          else el = tm + dsi_pkg::MsPerDay - s;
        end
      end
    end
    if (hit < 0) begin
      res.q8   = last_q8;
      res.slot = '0;
      return res;
    end
    if (dur <= 0) begin
      dur = 1;
      el  = 0;
    end
    if (el < 0) el = 0;
    if (el > dur) el = dur;
    to_lv   = longint'(sched[hit][dsi_pkg::LevelLsb +: dsi_pkg::LevelW]);
    from_lv = 0;
    p = (hit == 0) ? dsi_pkg::SlotCount - 1 : hit - 1;
    while (p != hit && !slot_on(sched[p]))
      p = (p == 0) ? dsi_pkg::SlotCount - 1 : p - 1;
    if (p != hit) from_lv = longint'(sched[p][dsi_pkg::LevelLsb +: dsi_pkg::LevelW]);
    if (sched[hit][dsi_pkg::ModeLsb +: dsi_pkg::ModeW] == dsi_pkg::ModeFixed) begin
      q = to_lv << dsi_pkg::FracBits;
    end else begin
      num = (from_lv * dur + (to_lv - from_lv) * el) << dsi_pkg::FracBits;
      if (num < 0) num = 0;
      q = num / dur;
    end
    if (q > dsi_pkg::FullQ8) q = dsi_pkg::FullQ8;
    last_q8  = dsi_pkg::IntW'(q);
    res.q8   = last_q8;
    res.slot = dsi_pkg::SlotOutW'(hit + 1);
    return res;
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic send_time(input logic [dsi_pkg::TimeW-1:0] t);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    time_of_day_ms_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    due_levels.push_back(predict_level(t));
  endtask

  // leaves valid high so that back-to-back writes stay one transfer apart
  task automatic write_slot(input logic [dsi_pkg::CfgIdxW-1:0] idx,
                            input logic [dsi_pkg::CfgW-1:0]    val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < dsi_pkg::RegCount) sched[idx] = val;
  endtask

  task automatic load_plan();
    int i;
    if ($urandom_range(0, 2) == 0)
      write_slot(dsi_pkg::CfgIdxW'($urandom_range(dsi_pkg::RegCount, 15)),
                 dsi_pkg::CfgW'($urandom()));
    for (i = 0; i < dsi_pkg::RegCount; i++) write_slot(dsi_pkg::CfgIdxW'(i), plan[i]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // day split at sorted boundaries, the last window wrapping; some slots disabled
  task automatic build_day_plan();
    int marks [$];
    int i, lv;
    for (i = 0; i < dsi_pkg::RegCount; i++) marks.push_back($urandom_range(0, 1439));
    marks.sort();
    for (i = 0; i < dsi_pkg::RegCount; i++) begin
      lv = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
      if ($urandom_range(0, 4) == 0)
        plan[i] = pack_slot(0, 0, dsi_pkg::ModeW'($urandom_range(0, 3)), lv);
      else
        plan[i] = pack_slot(marks[i], marks[(i + 1) % dsi_pkg::RegCount],
                            dsi_pkg::ModeW'($urandom_range(0, 3)), lv);
    end
  endtask

  task automatic build_noise_plan();
    int i, m;
    for (i = 0; i < dsi_pkg::RegCount; i++) begin
      case ($urandom_range(0, 3))
        0: plan[i] = dsi_pkg::CfgW'($urandom());
        1: begin
          m = $urandom_range(1, 2047);
          plan[i] = pack_slot(m, m, dsi_pkg::ModeW'($urandom_range(0, 3)),
                              $urandom_range(0, 127));
        end
        default: plan[i] = pack_slot($urandom_range(0, 2047), $urandom_range(0, 2047),
                                     dsi_pkg::ModeW'($urandom_range(0, 3)),
                                     $urandom_range(0, 127));
      endcase
    end
  endtask

  // mostly plain times of day, some on window edges, some over the full width
  function automatic logic [dsi_pkg::TimeW-1:0] pick_time();
    logic [dsi_pkg::CfgW-1:0] w;
    longint                   mark_ms;
    w = sched[$urandom_range(0, dsi_pkg::RegCount - 1)];
    case ($urandom_range(0, 9))
      0: return dsi_pkg::TimeW'($urandom());
      1, 2, 3: begin
        if ($urandom_range(0, 1) == 1)
          mark_ms = longint'(w[dsi_pkg::EndLsb +: dsi_pkg::MinW]) * dsi_pkg::MsPerMin;
        else
          mark_ms = longint'(w[dsi_pkg::StartLsb +: dsi_pkg::MinW]) * dsi_pkg::MsPerMin;
        mark_ms = mark_ms + $urandom_range(0, 3) - 2;
        if (mark_ms < 0) mark_ms = 0;
        return dsi_pkg::TimeW'(mark_ms);
      end
      default: return dsi_pkg::TimeW'($urandom_range(0, dsi_pkg::MsPerDay - 1));
    endcase
  endfunction

  task automatic test_reset_schedule();
    logic [dsi_pkg::TimeW-1:0] probes [10];
    probes = '{0, 21599999, 21600000, 25200000, 28800000, 68400000, 72000000,
               86399999, 86400000, {dsi_pkg::TimeW{1'b1}}};
    foreach (probes[i]) send_time(probes[i]);
  endtask

  task automatic test_special_slots();
    logic [dsi_pkg::TimeW-1:0] probes [13];
    settle();
    plan[0] = pack_slot(0, 0, dsi_pkg::ModeFixed, 127);     // disabled
    plan[1] = pack_slot(300, 300, dsi_pkg::ModeFixed, 50);  // empty window
    plan[2] = pack_slot(360, 720, ModeRamp, 127);           // level above 100
    plan[3] = pack_slot(720, 780, ModeRampOdd, 20);         // falling ramp
    plan[4] = pack_slot(2047, 10, ModeRamp, 60);            // wrap, negative span
    plan[5] = pack_slot(1320, 120, ModeRampAlt, 80);        // wrap past midnight
    plan[6] = '1;
    plan[7] = pack_slot(840, 900, dsi_pkg::ModeFixed, 90);
    load_plan();
    probes = '{21600000, 32400000, 43199999, 43200000, 45000000, 48600000, 18000000,
               130000000, 0, 100000000, 82800000, 3600000, 52200000};
    foreach (probes[i]) send_time(probes[i]);
    // lone enabled slot ramps up from zero; out-of-range indexes must not land
    settle();
    foreach (plan[i]) plan[i] = '0;
    plan[3] = pack_slot(60, 180, ModeRamp, 100);
    write_slot(dsi_pkg::CfgIdxW'(15), '1);
    write_slot(dsi_pkg::CfgIdxW'(dsi_pkg::RegCount), '1);
    load_plan();
    send_time(5400000);
    send_time(100);
  endtask

  task automatic test_random_schedules();
    int phase, n;
    for (phase = 0; phase < PhaseCount; phase++) begin
      settle();
      if (phase % 3 == 1) build_noise_plan();
      else build_day_plan();
      if (phase == 7) foreach (plan[i]) plan[i] = dsi_pkg::SlotReset[i];
      load_plan();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PhaseItems; n++) send_time(pick_time());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    int n;
    settle();
    build_day_plan();
    load_plan();
    tx_steady = 1'b1;
    hold_len  = HoldCycles;
    for (n = 0; n < 50; n++) send_time(pick_time());
    tx_steady = 1'b0;
  endtask

  initial begin : rx_side
    int pause;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      pause = rx_steady ? 0 : $urandom_range(0, 18);
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin : level_check
    level_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_levels.size() == 0) begin
        flag_error($sformatf("unexpected result intensity %0d slot %0d",
                             intensity_q8_o, active_slot_o));
      end else begin
        want = due_levels.pop_front();
        if (intensity_q8_o !== want.q8)
          flag_error($sformatf("intensity_q8 expected %0d actual %0d",
                               want.q8, intensity_q8_o));
        if (active_slot_o !== want.slot)
          flag_error($sformatf("active_slot expected %0d actual %0d",
                               want.slot, active_slot_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i       <= 1'b0;
    time_of_day_ms_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    foreach (sched[i]) sched[i] = dsi_pkg::SlotReset[i];
    last_q8 = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_schedule();
    test_special_slots();
    test_random_schedules();
    test_backpressure();
    settle();
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
